// ----- rtl/rc6_pkg.sv -----
// Shared types, constants and rotate functions of the RC6 block cipher.
`default_nettype none
package rc6_pkg;
   localparam logic [31:0] P32 = 32'hB7E15163;
   localparam logic [31:0] Q32 = 32'h9E3779B9;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LEN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MODE = 3'd5;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } block_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] w;
      w = {x, x} << n;
      return w[63:32];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] w;
      w = {x, x} >> n;
      return w[31:0];
   endfunction
endpackage
`default_nettype wire

// ----- rtl/rc6_block_if.sv -----
// Valid/ready channel that carries one 128-bit block.
`default_nettype none
interface rc6_block_if
   import rc6_pkg::*;
();
   logic valid;
   logic ready;
   block_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/rc6_rk_mem.sv -----
// Round key memory with one write port and one registered read port.
`default_nettype none
module rc6_rk_mem #(
   parameter int DEPTH = 44,
   parameter int AW = 6
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [AW-1:0] wr_addr,
   input wire logic [31:0] wr_data,
   input wire logic [AW-1:0] rd_addr,
   output logic [31:0] rd_data
);
   logic [31:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/rc6_block_cipher_top.sv -----
// Top level of the RC6 block cipher with key schedule and round engine.
// After a key write, the first request triggers key expansion: the
// 2*ROUNDS+4 round key words are seeded into the round key memory, then
// 3*max(c,2*ROUNDS+4) mixing steps follow, each a memory read and then a
// write back, where c is the key length in 32-bit words. The single read
// port of the round key memory delivers one round key per cycle, so each
// round and the first whitening step read their key pair one key after
// the other. ST_PRE fetches the first key pair before the rounds; the
// final whitening step and the loading of the result in ST_POST follow
// the rounds. One request is processed at a time. The next one is
// accepted back in ST_IDLE, once the result is taken or is being taken.
`default_nettype none
module rc6_block_cipher_top
   import rc6_pkg::*;
#(
   parameter int ROUNDS = 20,
   parameter int MAX_KEY_BYTES = 32
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_we,
   input wire logic [CSR_IDX_W-1:0] csr_index,
   input wire logic [CSR_DATA_W-1:0] csr_wdata,
   rc6_block_if.sink req,
   rc6_block_if.source rsp
);
   localparam int NRK = 2 * ROUNDS + 4;
   localparam int AW = $clog2(NRK);
   localparam int NLW = (MAX_KEY_BYTES + 3) / 4;
   localparam int LW = (NLW > 1) ? $clog2(NLW) : 1;
   localparam int VMAX = 3 * ((NLW > NRK) ? NLW : NRK);
   localparam int SW = $clog2(VMAX + 1);
   localparam int LENW = $clog2(MAX_KEY_BYTES + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEED, ST_MIX_RD, ST_MIX_WR, ST_PRE, ST_ROUND, ST_POST
   } state_type;

   state_type state_ff;
   logic [63:0] key_ff [4];
   logic [5:0] klen_ff;
   logic mode_ff, sched_valid_ff;
   logic [31:0] lw_ff [NLW];
   logic [LW-1:0] j_ff;
   logic [LENW:0] cw_ff;
   logic [AW-1:0] i_ff;
   logic [SW-1:0] s_ff, v_ff;
   logic [31:0] ma_ff, mb_ff, seed_ff;
   block_type blk_ff;
   logic [31:0] k0_ff;
   logic [5:0] rnd_ff;
   logic phase_ff;
   block_type out_ff;
   logic out_valid_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0] wr_data, rd_data;

   rc6_rk_mem #(.DEPTH(NRK), .AW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [LENW-1:0] len_use;
   always_comb begin
      if ({2'b00, klen_ff} > 8'(MAX_KEY_BYTES)) begin
         len_use = LENW'(MAX_KEY_BYTES);
      end else begin
         len_use = LENW'(klen_ff);
      end
   end

   function automatic logic [31:0] fmix(input logic [31:0] x);
      logic [31:0] p;
      p = x * {x[30:0], 1'b1};
      return rotl(p, 5'd5);
   endfunction

   // Mixing step values.
   logic [31:0] new_a, new_b, ab;
   assign new_a = rotl(rd_data + ma_ff + mb_ff, 5'd3);
   assign ab = new_a + mb_ff;
   assign new_b = rotl(lw_ff[j_ff] + ab, ab[4:0]);

   logic key_write, sched_done;
   assign key_write = csr_we && (csr_index == REG_KEY_0 || csr_index == REG_KEY_1 ||
                                 csr_index == REG_KEY_2 || csr_index == REG_KEY_3 ||
                                 csr_index == REG_KEY_LEN);
   assign sched_done = (state_ff == ST_MIX_WR) && (s_ff + 1'b1 == v_ff);

   // Round datapath; each round has two phases. Phase 0 updates the block,
   // phase 1 captures the first key of the next pair.
   logic [31:0] t_enc, u_enc, t_dec, u_dec;
   block_type rotd;
   assign t_enc = fmix(blk_ff.b);
   assign u_enc = fmix(blk_ff.d);
   assign rotd = '{a: blk_ff.d, b: blk_ff.a, c: blk_ff.b, d: blk_ff.c};
   assign t_dec = fmix(rotd.b);
   assign u_dec = fmix(rotd.d);

   assign req.ready = (state_ff == ST_IDLE) && !(out_valid_ff && !rsp.ready);
   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;

   logic [AW-1:0] key_addr;
   logic [5:0] pair_idx;
   always_comb begin
      wr_en = 1'b0;
      wr_addr = i_ff;
      wr_data = seed_ff;
      key_addr = '0;
      unique case (state_ff)
         ST_SEED: begin
            wr_en = 1'b1;
         end
         ST_MIX_WR: begin
            wr_en = 1'b1;
            wr_data = new_a;
         end
         default: begin
         end
      endcase
      // While the rounds run, the key pair of the following round is fetched.
      if (state_ff == ST_ROUND && rnd_ff != 6'(ROUNDS + 1)) begin
         pair_idx = rnd_ff + 6'd1;
      end else begin
         pair_idx = rnd_ff;
      end
      if (mode_ff) begin
         key_addr = AW'(NRK - 2 - 2 * int'(pair_idx)) + AW'(phase_ff);
      end else begin
         key_addr = AW'(2 * int'(pair_idx)) + AW'(phase_ff);
      end
      rd_addr = (state_ff == ST_MIX_RD) ? i_ff : key_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         key_ff[0] <= '0;
         key_ff[1] <= '0;
         key_ff[2] <= '0;
         key_ff[3] <= '0;
         klen_ff <= 6'd16;
         mode_ff <= 1'b0;
         sched_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3: begin
                  key_ff[csr_index[1:0]] <= csr_wdata;
               end
               REG_KEY_LEN: begin
                  klen_ff <= csr_wdata[5:0];
               end
               REG_MODE: begin
                  mode_ff <= csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         if (key_write) begin
            sched_valid_ff <= 1'b0;
         end else if (sched_done) begin
            sched_valid_ff <= 1'b1;
         end
         if (state_ff == ST_POST) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               rnd_ff <= '0;
               phase_ff <= 1'b0;
               if (req.valid && req.ready) begin
                  blk_ff <= req.data;
                  if (sched_valid_ff) begin
                     state_ff <= ST_PRE;
                  end else begin
                     for (int w = 0; w < NLW; w++) begin
                        for (int y = 0; y < 4; y++) begin
                           if ((4 * w + y) < int'(len_use) && (4 * w + y) < 32) begin
                              lw_ff[w][8*y +: 8] <= key_ff[(4*w+y)/8][8*((4*w+y)%8) +: 8];
                           end else begin
                              lw_ff[w][8*y +: 8] <= 8'h00;
                           end
                        end
                     end
                     if (len_use == '0) begin
                        cw_ff <= (LENW+1)'(1);
                     end else begin
                        cw_ff <= ((LENW+1)'(len_use) + (LENW+1)'(3)) >> 2;
                     end
                     i_ff <= '0;
                     seed_ff <= P32;
                     state_ff <= ST_SEED;
                  end
               end
            end
            ST_SEED: begin
               seed_ff <= seed_ff + Q32;
               if (i_ff == AW'(NRK - 1)) begin
                  i_ff <= '0;
                  j_ff <= '0;
                  s_ff <= '0;
                  ma_ff <= '0;
                  mb_ff <= '0;
                  v_ff <= (int'(cw_ff) > NRK) ? SW'(3 * int'(cw_ff)) : SW'(3 * NRK);
                  state_ff <= ST_MIX_RD;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            ST_MIX_RD: begin
               state_ff <= ST_MIX_WR;
            end
            ST_MIX_WR: begin
               ma_ff <= new_a;
               mb_ff <= new_b;
               lw_ff[j_ff] <= new_b;
               i_ff <= (i_ff == AW'(NRK - 1)) ? '0 : i_ff + 1'b1;
               j_ff <= ((LENW+1)'(j_ff) + 1'b1 == cw_ff) ? '0 : j_ff + 1'b1;
               s_ff <= s_ff + 1'b1;
               if (sched_done) begin
                  state_ff <= ST_PRE;
               end else begin
                  state_ff <= ST_MIX_RD;
               end
            end
            ST_PRE: begin
               // Reads the whitening pair; the registered read port returns the data in the next cycle.
               phase_ff <= ~phase_ff;
               if (phase_ff) begin
                  k0_ff <= rd_data;
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               phase_ff <= ~phase_ff;
               if (!phase_ff) begin
                  // rd_data holds the second key of the pair for this round.
                  if (rnd_ff == '0) begin
                     if (mode_ff) begin
                        blk_ff.a <= blk_ff.a - k0_ff;
                        blk_ff.c <= blk_ff.c - rd_data;
                     end else begin
                        blk_ff.b <= blk_ff.b + k0_ff;
                        blk_ff.d <= blk_ff.d + rd_data;
                     end
                  end else if (rnd_ff == 6'(ROUNDS + 1)) begin
                     if (mode_ff) begin
                        blk_ff.b <= blk_ff.b - k0_ff;
                        blk_ff.d <= blk_ff.d - rd_data;
                     end else begin
                        blk_ff.a <= blk_ff.a + k0_ff;
                        blk_ff.c <= blk_ff.c + rd_data;
                     end
                  end else begin
                     if (mode_ff) begin
                        blk_ff.a <= rotr(rotd.a - k0_ff, u_dec[4:0]) ^ t_dec;
                        blk_ff.b <= rotd.b;
                        blk_ff.c <= rotr(rotd.c - rd_data, t_dec[4:0]) ^ u_dec;
                        blk_ff.d <= rotd.d;
                     end else begin
                        blk_ff.a <= blk_ff.b;
                        blk_ff.b <= rotl(blk_ff.c ^ u_enc, t_enc[4:0]) + rd_data;
                        blk_ff.c <= blk_ff.d;
                        blk_ff.d <= rotl(blk_ff.a ^ t_enc, u_enc[4:0]) + k0_ff;
                     end
                  end
                  if (rnd_ff == 6'(ROUNDS + 1)) begin
                     state_ff <= ST_POST;
                  end
               end else begin
                  k0_ff <= rd_data;
                  rnd_ff <= rnd_ff + 1'b1;
               end
            end
            ST_POST: begin
               out_ff <= blk_ff;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench of the RC6 block cipher: directed and random blocks under key changes.
`default_nettype none
module testbench;
   import rc6_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rc6_block_if req_ch ();
   rc6_block_if rsp_ch ();

   rc6_block_cipher_top dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   logic [63:0] key_regs [4];
   logic [5:0] key_len_reg;
   logic decrypt_mode;
   logic keys_ready;
   logic [31:0] rk [44];

   block_type expected_blocks [$];
   int errors = 0;
   int blocks_sent = 0;
   int blocks_checked = 0;
   bit long_stall = 0;

   typedef struct {
      block_type blk;
      bit has_expect;
      block_type expect_blk;
   } stim_row;

   function automatic logic [31:0] rol32(logic [31:0] x, logic [31:0] n);
      logic [4:0] k;
      k = n[4:0];
      return (k == 0) ? x : ((x << k) | (x >> (32 - k)));
   endfunction

   function automatic logic [31:0] ror32(logic [31:0] x, logic [31:0] n);
      logic [4:0] k;
      k = n[4:0];
      return (k == 0) ? x : ((x >> k) | (x << (32 - k)));
   endfunction

   task automatic expand_schedule();
      int len, c, v;
      logic [31:0] l [8];
      logic [31:0] x, y;
      int i, j;
      len = (key_len_reg > 32) ? 32 : key_len_reg;
      c = (len + 3) / 4;
      if (c == 0) c = 1;
      for (i = 0; i < 8; i++) l[i] = 0;
      for (i = 0; i < len; i++)
         l[i / 4] |= {24'd0, key_regs[i / 8][(i % 8) * 8 +: 8]} << ((i % 4) * 8);
      rk[0] = P32;
      for (i = 1; i < 44; i++) rk[i] = rk[i - 1] + Q32;
      v = 3 * ((c > 44) ? c : 44);
      x = 0;
      y = 0;
      i = 0;
      j = 0;
      for (int s = 0; s < v; s++) begin
         rk[i] = rol32(rk[i] + x + y, 3);
         x = rk[i];
         l[j] = rol32(l[j] + x + y, x + y);
         y = l[j];
         i = (i + 1) % 44;
         j = (j + 1) % c;
      end
      keys_ready = 1;
   endtask

   task automatic cipher_block(input block_type inb, output block_type outb);
      logic [31:0] a, b, c, d, t, u, x;
      if (!keys_ready) expand_schedule();
      a = inb.a;
      b = inb.b;
      c = inb.c;
      d = inb.d;
      if (!decrypt_mode) begin
         b += rk[0];
         d += rk[1];
         for (int i = 2; i <= 40; i += 2) begin
            t = rol32(b * (2 * b + 1), 5);
            u = rol32(d * (2 * d + 1), 5);
            a = rol32(a ^ t, u) + rk[i];
            c = rol32(c ^ u, t) + rk[i + 1];
            x = a; a = b; b = c; c = d; d = x;
         end
         a += rk[42];
         c += rk[43];
      end else begin
         c -= rk[43];
         a -= rk[42];
         for (int i = 40; i >= 2; i -= 2) begin
            x = d; d = c; c = b; b = a; a = x;
            u = rol32(d * (2 * d + 1), 5);
            t = rol32(b * (2 * b + 1), 5);
            c = ror32(c - rk[i + 1], t) ^ u;
            a = ror32(a - rk[i], u) ^ t;
         end
         d -= rk[1];
         b -= rk[0];
      end
      outb = '{a: a, b: b, c: c, d: d};
   endtask

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("rc6_block_cipher_top regression: fail");
      $finish;
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      if (idx <= REG_KEY_3) begin
         key_regs[idx[1:0]] = val;
         keys_ready = 0;
      end else if (idx == REG_KEY_LEN) begin
         key_len_reg = val[5:0];
         keys_ready = 0;
      end else if (idx == REG_MODE) begin
         decrypt_mode = val[0];
      end
   endtask

   task automatic send_block(input block_type blk, input bit has_exp, input block_type exp_blk);
      block_type pred;
      @(negedge clock);
      req_ch.valid <= 1;
      req_ch.data <= blk;
      do @(posedge clock); while (!req_ch.ready);
      cipher_block(blk, pred);
      if (has_exp && pred != exp_blk) begin
         $error("directed row: table %h predictor %h", exp_blk, pred);
         errors++;
      end
      expected_blocks.push_back(pred);
      blocks_sent++;
      @(negedge clock);
      req_ch.valid <= 0;
   endtask

   task automatic send_burst_block(input block_type blk);
      block_type pred;
      req_ch.valid <= 1;
      req_ch.data <= blk;
      do @(posedge clock); while (!req_ch.ready);
      cipher_block(blk, pred);
      expected_blocks.push_back(pred);
      blocks_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic block_type rand_block();
      return '{a: $urandom, b: $urandom, c: $urandom, d: $urandom};
   endfunction

   task automatic random_phase(input int count);
      int n, burst, gap;
      n = 0;
      while (n < count) begin
         burst = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
         if (gap > 0) begin
            req_ch.valid <= 0;
            repeat (gap) @(negedge clock);
         end
         for (int k = 0; k < burst && n < count; k++) begin
            send_burst_block(rand_block());
            n++;
         end
      end
      req_ch.valid <= 0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_blocks.size() == 0) begin
            $error("unexpected result %h", rsp_ch.data);
            errors++;
         end else begin
            block_type e;
            e = expected_blocks.pop_front();
            if (rsp_ch.data.a !== e.a) begin
               $error("out_a expected %h actual %h", e.a, rsp_ch.data.a); errors++;
            end
            if (rsp_ch.data.b !== e.b) begin
               $error("out_b expected %h actual %h", e.b, rsp_ch.data.b); errors++;
            end
            if (rsp_ch.data.c !== e.c) begin
               $error("out_c expected %h actual %h", e.c, rsp_ch.data.c); errors++;
            end
            if (rsp_ch.data.d !== e.d) begin
               $error("out_d expected %h actual %h", e.d, rsp_ch.data.d); errors++;
            end
            blocks_checked++;
         end
      end
   end

   initial begin
      int cnt;
      rsp_ch.ready = 0;
      cnt = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (long_stall) begin
            rsp_ch.ready <= 0;
            repeat (300) @(negedge clock);
            long_stall = 0;
         end
         cnt++;
         if ((cnt / 200) % 2 == 0) rsp_ch.ready <= 1;
         else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   stim_row directed [$];

   initial begin
      block_type z, ones;
      int lens [5];
      reset = 1;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 0;
      req_ch.data = '0;
      for (int i = 0; i < 4; i++) key_regs[i] = 0;
      key_len_reg = 16;
      decrypt_mode = 0;
      keys_ready = 0;
      lens = '{0, 1, 32, 63, 33};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      z = '0;
      ones = '{default: 32'hFFFF_FFFF};
      // Published vector: all-zero 16-byte key, all-zero plaintext.
      directed.push_back('{blk: z, has_expect: 1,
                           expect_blk: '{a: 32'h36a5c38f, b: 32'h78f7b156,
                                         c: 32'h4edf29c1, d: 32'h1ea44898}});
      directed.push_back('{blk: ones, has_expect: 0, expect_blk: z});
      directed.push_back('{blk: '{a: 32'h8000_0000, b: 1, c: 32'h7FFF_FFFF, d: 32'hFFFF_FFFE},
                           has_expect: 0, expect_blk: z});
      foreach (directed[i]) send_block(directed[i].blk, directed[i].has_expect,
                                       directed[i].expect_blk);
      drain();

      write_csr(REG_MODE, 64'd1);
      send_block('{a: 32'h36a5c38f, b: 32'h78f7b156, c: 32'h4edf29c1, d: 32'h1ea44898},
                 1, z);
      send_block(ones, 0, z);
      drain();

      // Extremes of the key length, including the empty and oversized keys.
      for (int kl = 0; kl < 5; kl++) begin
         write_csr(REG_KEY_0, kl[0] ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
         write_csr(REG_KEY_1, {$urandom, $urandom});
         write_csr(REG_KEY_2, 64'hFFFF_FFFF_FFFF_FFFF);
         write_csr(REG_KEY_3, {$urandom, $urandom});
         write_csr(REG_KEY_LEN, 64'(lens[kl]));
         write_csr(REG_MODE, 64'(kl % 2));
         write_csr(REG_UNUSED_LO, 64'hFFFF);
         write_csr(REG_UNUSED_HI, 64'h1);
         send_block(z, 0, z);
         send_block(ones, 0, z);
         send_block(rand_block(), 0, z);
         drain();
      end

      // Random phases under changing keys and modes.
      for (int ph = 0; ph < 8; ph++) begin
         for (int w = 0; w < 4; w++) write_csr(CSR_IDX_W'(w), {$urandom, $urandom});
         write_csr(REG_KEY_LEN, (ph == 7) ? 64'd32 : 64'($urandom_range(0, 63)));
         write_csr(REG_MODE, 64'($urandom_range(0, 1)));
         if (ph == 3) long_stall = 1;
         random_phase(75);
         drain();
      end

      $display("Sent %0d blocks, checked %0d results over key lengths 0 to 63 in both modes.",
               blocks_sent, blocks_checked);
      if (errors == 0 && expected_blocks.size() == 0) begin
         $display("rc6_block_cipher_top regression: pass");
      end else begin
         $display("rc6_block_cipher_top regression: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
